[rtl/sphsub_pkg.sv]
package sphsub_pkg;

  // Status returned by the normalization unit.
  typedef struct packed {
    logic done;
    logic deg;
  } norm_stat_t;

  // 0.3333 in Q0.16, rounded down.
  localparam logic [14:0] THIRD_Q16 = 15'd21843;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 8'd3;

  localparam logic [1:0] LAST_CHILD = 2'd3;
  localparam logic [1:0] LAST_CORNER = 2'd2;

  // Vertex slot of corner j of child k. Slots 0..2 are the originals,
  // slots 3..5 the projected midpoints m01, m12, m20.
  function automatic logic [2:0] child_vert(input logic [1:0] k, input logic [1:0] j);
    logic [2:0] v;
    v = 3'd0;
    case (k)
      2'd0: v = (j == 2'd0) ? 3'd0 : ((j == 2'd1) ? 3'd3 : 3'd5);
      2'd1: v = (j == 2'd0) ? 3'd1 : ((j == 2'd1) ? 3'd3 : 3'd4);
      2'd2: v = (j == 2'd0) ? 3'd2 : ((j == 2'd1) ? 3'd4 : 3'd5);
      2'd3: v = (j == 2'd0) ? 3'd3 : ((j == 2'd1) ? 3'd4 : 3'd5);
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/sphsub_fifo.sv]
module sphsub_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/sphsub_norm.sv]
module sphsub_norm import sphsub_pkg::*; #(
  parameter int DW = 34,
  parameter int NB = 30,
  parameter int MW = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2:0][DW-1:0]     d,
  input  logic [MW-1:0]          m,
  output norm_stat_t             stat,
  output logic [2:0][MW+1:0]     r
);

  localparam int UN     = (DW > NB + 1) ? DW : NB + 1;
  localparam int SQW    = 2 * NB + 2;
  localparam int RTW    = NB + 1;
  localparam int REMW   = NB + 4;
  localparam int QW     = MW + 1;
  localparam int PW     = NB + MW + 1;
  localparam int LW     = NB + 2;
  localparam int RW     = MW + 2;
  localparam int CNTMAX = (QW > RTW) ? QW : RTW;
  localparam int CW     = $clog2(CNTMAX + 1);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_MUL   = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  localparam logic [UN-1:0] TOP_LIM = UN'(1) << NB;
  localparam logic [UN-1:0] BOT_LIM = UN'(1) << (NB - 1);

  logic [2:0]          state;
  logic [UN-1:0]       u [3];
  logic [2:0]          neg;
  logic [UN-1:0]       mx;
  logic [MW-1:0]       mreg;
  logic [SQW-1:0]      sq;
  logic [RTW-1:0]      root;
  logic [REMW-1:0]     srem;
  logic [LW-1:0]       drem;
  logic [QW-1:0]       dlow;
  logic [QW-1:0]       q;
  logic [1:0]          idx;
  logic [CW-1:0]       cnt;

  logic [UN-1:0]       mag [3];
  logic [UN-1:0]       mag_max;
  logic [NB-1:0]       usel;
  logic [REMW-1:0]     rs;
  logic [REMW-1:0]     trial;
  logic [PW-1:0]       dividend;
  logic [LW-1:0]       t;
  logic                qbit;
  logic [QW-1:0]       qn;
  logic [QW-1:0]       qc;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = UN'(d[j][DW-1] ? (~d[j] + DW'(1)) : d[j]);
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) begin
      mag_max = mag[1];
    end
    if (mag[2] > mag_max) begin
      mag_max = mag[2];
    end
    usel     = u[idx][NB-1:0];
    rs       = {srem[REMW-3:0], sq[SQW-1:SQW-2]};
    trial    = REMW'({root, 2'b01});
    dividend = PW'(usel * mreg) + PW'(root >> 1);
    t        = {drem[LW-2:0], dlow[QW-1]};
    qbit     = (t >= LW'(root));
    qn       = {q[QW-2:0], qbit};
    qc       = (qn > QW'(mreg)) ? QW'(mreg) : qn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= N_IDLE;
      stat.done <= 1'b0;
      stat.deg  <= 1'b0;
      idx       <= 2'd0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int j = 0; j < 3; j++) begin
              u[j]   <= mag[j];
              neg[j] <= d[j][DW-1];
            end
            mx   <= mag_max;
            mreg <= m;
            if (mag_max == '0) begin
              r         <= '0;
              stat.done <= 1'b1;
              stat.deg  <= 1'b1;
            end else begin
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (mx >= TOP_LIM) begin
            mx <= mx >> 1;
            for (int j = 0; j < 3; j++) begin
              u[j] <= u[j] >> 1;
            end
          end else if (mx < BOT_LIM) begin
            mx <= mx << 1;
            for (int j = 0; j < 3; j++) begin
              u[j] <= u[j] << 1;
            end
          end else begin
            sq    <= '0;
            idx   <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq  <= sq + SQW'(usel * usel);
          idx <= idx + 2'd1;
          if (idx == 2'd2) begin
            root  <= '0;
            srem  <= '0;
            cnt   <= '0;
            state <= N_ROOT;
          end
        end
        N_ROOT: begin
          // One result bit of the integer square root per cycle.
          if (rs >= trial) begin
            srem <= rs - trial;
            root <= {root[RTW-2:0], 1'b1};
          end else begin
            srem <= rs;
            root <= {root[RTW-2:0], 1'b0};
          end
          sq  <= sq << 2;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(RTW - 1)) begin
            idx   <= 2'd0;
            state <= N_MUL;
          end
        end
        N_MUL: begin
          // The top bits of the dividend are always below the length.
          drem  <= LW'(dividend >> QW);
          dlow  <= dividend[QW-1:0];
          q     <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          drem <= qbit ? (t - LW'(root)) : t;
          dlow <= dlow << 1;
          q    <= qn;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(QW - 1)) begin
            r[idx] <= neg[idx] ? (~RW'(qc) + RW'(1)) : RW'(qc);
            idx    <= idx + 2'd1;
            if (idx == 2'd2) begin
              stat.done <= 1'b1;
              stat.deg  <= 1'b0;
              state     <= N_IDLE;
            end else begin
              state <= N_MUL;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

[rtl/sphsub_front.sv]
module sphsub_front import sphsub_pkg::*; #(
  parameter int W = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [9*W+23:0]               in_data,
  input  logic [W-1:0]                  center_x,
  input  logic [W-1:0]                  center_y,
  input  logic [W-1:0]                  center_z,
  output logic                          push,
  input  logic                          push_ready,
  output logic [9*W+24+9*(W+1)-1:0]     push_data
);

  localparam int IN_RAW = 9 * W + 24;

  logic              sv;
  logic [IN_RAW-1:0] sdata;
  logic [W-1:0]      cen [3];
  logic [W:0]        vsum;
  logic [W-1:0]      mid;
  logic [9*(W+1)-1:0] dl;

  assign cen[0]   = center_x;
  assign cen[1]   = center_y;
  assign cen[2]   = center_z;
  assign in_ready = !sv || push_ready;
  assign push     = sv;

  // Midpoint of each edge, floored, relative to the sphere center.
  always_comb begin
    dl   = '0;
    vsum = '0;
    mid  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        vsum = $signed({sdata[(3*i+j)*W+W-1], sdata[(3*i+j)*W +: W]})
             + $signed({sdata[(3*((i+1)%3)+j)*W+W-1], sdata[(3*((i+1)%3)+j)*W +: W]});
        mid  = vsum[W:1];
        dl[(3*i+j)*(W+1) +: (W+1)] = $signed({mid[W-1], mid}) - $signed({cen[j][W-1], cen[j]});
      end
    end
    push_data = {dl, sdata};
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sdata <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (in_valid && in_ready) begin
      sv <= 1'b1;
    end else if (push_ready) begin
      sv <= 1'b0;
    end
  end

endmodule

[rtl/sphsub_back.sv]
module sphsub_back import sphsub_pkg::*; #(
  parameter int W  = 32,
  parameter int NW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  logic [9*W+24+9*(W+1)-1:0] q_data,
  output logic                      q_pop,
  input  logic [W-1:0]              center_x,
  input  logic [W-1:0]              center_y,
  input  logic [W-1:0]              center_z,
  input  logic [W-2:0]              radius,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [((3*W+3*NW+24+7)/8)*8-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  output logic [7:0]                m_axis_tuser
);

  localparam int IN_RAW  = 9 * W + 24;
  localparam int NB      = ((62 - W) < 30) ? (62 - W) : 30;
  localparam int MW      = ((W - 1) > (NW - 1)) ? (W - 1) : (NW - 1);
  localparam int DW      = W + 2;
  localparam int RW      = MW + 2;
  localparam int SW      = MW + 3;
  localparam int PRW     = W + 18;
  localparam int OUT_RAW = 3 * W + 3 * NW + 24;
  localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8;

  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_PSTART = 3'd1;
  localparam logic [2:0] B_PWAIT  = 3'd2;
  localparam logic [2:0] B_CSUM   = 3'd3;
  localparam logic [2:0] B_CMUL   = 3'd4;
  localparam logic [2:0] B_CSUB   = 3'd5;
  localparam logic [2:0] B_NWAIT  = 3'd6;
  localparam logic [2:0] B_EMIT   = 3'd7;

  logic [2:0]           state;
  logic [W-1:0]         vert [6][3];
  logic [5:0]           vdeg;
  logic [W:0]           dmid [3][3];
  logic [23:0]          col;
  logic [1:0]           mi;
  logic [1:0]           k;
  logic [1:0]           cnt;
  logic [DW-1:0]        s [3];
  logic [PRW-1:0]       cp [3];
  logic [2:0][DW-1:0]   nd;
  logic [MW-1:0]        nm;
  logic                 nstart;
  logic [NW-1:0]        nrm [3];
  logic                 ndeg;

  norm_stat_t           nstat;
  logic [2:0][RW-1:0]   nr;
  logic [W-1:0]         cen [3];
  logic [2:0]           vidx;
  logic signed [SW-1:0] psum [3];
  logic [W-1:0]         psat [3];
  logic                 out_free;

  assign cen[0]   = center_x;
  assign cen[1]   = center_y;
  assign cen[2]   = center_z;
  assign vidx     = child_vert(k, cnt);
  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Projected midpoint: center plus scaled offset, saturated.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      psum[j] = $signed({{(SW-W){cen[j][W-1]}}, cen[j]})
              + $signed({nr[j][RW-1], nr[j]});
      if (psum[j] > SAT_HI) begin
        psat[j] = SAT_HI[W-1:0];
      end else if (psum[j] < SAT_LO) begin
        psat[j] = SAT_LO[W-1:0];
      end else begin
        psat[j] = psum[j][W-1:0];
      end
    end
  end

  sphsub_norm #(
    .DW (DW),
    .NB (NB),
    .MW (MW)
  ) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .d     (nd),
    .m     (nm),
    .stat  (nstat),
    .r     (nr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      nstart        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      mi            <= 2'd0;
      k             <= 2'd0;
      cnt           <= 2'd0;
    end else begin
      nstart <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                vert[i][j] <= q_data[(3*i+j)*W +: W];
                dmid[i][j] <= q_data[IN_RAW + (3*i+j)*(W+1) +: (W+1)];
              end
            end
            col   <= q_data[9*W +: 24];
            vdeg  <= '0;
            mi    <= 2'd0;
            state <= B_PSTART;
          end
        end
        B_PSTART: begin
          for (int j = 0; j < 3; j++) begin
            nd[j] <= {dmid[mi][j][W], dmid[mi][j]};
          end
          nm     <= MW'(radius);
          nstart <= 1'b1;
          state  <= B_PWAIT;
        end
        B_PWAIT: begin
          if (nstat.done) begin
            for (int j = 0; j < 3; j++) begin
              vert[3'(mi) + 3'd3][j] <= psat[j];
            end
            vdeg[3'(mi) + 3'd3] <= nstat.deg;
            mi <= mi + 2'd1;
            if (mi == 2'd2) begin
              k     <= 2'd0;
              cnt   <= 2'd0;
              state <= B_CSUM;
            end else begin
              state <= B_PSTART;
            end
          end
        end
        B_CSUM: begin
          for (int j = 0; j < 3; j++) begin
            s[j] <= ((cnt == 2'd0) ? DW'(0) : s[j])
                  + {{2{vert[vidx][j][W-1]}}, vert[vidx][j]};
          end
          cnt <= cnt + 2'd1;
          if (cnt == LAST_CORNER) begin
            state <= B_CMUL;
          end
        end
        B_CMUL: begin
          for (int j = 0; j < 3; j++) begin
            cp[j] <= $signed(s[j]) * $signed({1'b0, THIRD_Q16});
          end
          state <= B_CSUB;
        end
        B_CSUB: begin
          for (int j = 0; j < 3; j++) begin
            nd[j] <= cp[j][PRW-1:16] - {{2{cen[j][W-1]}}, cen[j]};
          end
          nm     <= MW'(1) << (NW - 2);
          nstart <= 1'b1;
          state  <= B_NWAIT;
        end
        B_NWAIT: begin
          if (nstat.done) begin
            for (int j = 0; j < 3; j++) begin
              nrm[j] <= nr[j][NW-1:0];
            end
            ndeg  <= nstat.deg;
            cnt   <= 2'd0;
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_DW'({col, nrm[2], nrm[1], nrm[0],
                                      vert[vidx][2], vert[vidx][1], vert[vidx][0]});
            m_axis_tlast  <= (k == LAST_CHILD) && (cnt == LAST_CORNER);
            m_axis_tuser  <= {5'd0, ndeg | vdeg[vidx], k};
            cnt           <= cnt + 2'd1;
            if (cnt == LAST_CORNER) begin
              cnt <= 2'd0;
              if (k == LAST_CHILD) begin
                state <= B_IDLE;
              end else begin
                k     <= k + 2'd1;
                state <= B_CSUM;
              end
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/sphere_triangle_subdivide.sv]
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tdata: triangle and colour
// m_axis   out        m_axis_tvalid / m_axis_tready  tdata, tlast, tuser: one vertex
// cfg      in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Each input transaction yields twelve output transactions. The front stage
// registers the triangle and forms the three midpoint offsets; a two-entry
// queue holds triangles while the back part works. The back part runs seven
// normalizations on one shared sequential unit (three midpoint projections and
// four child normals), each made of an alignment shift, a sum of squares, an
// (NB+1)-bit square root and an (MW+1)-bit division per component, where
// NB = min(62-COORD_WIDTH, 30) and MW = max(COORD_WIDTH-1, NORMAL_WIDTH-1);
// that unit sets the throughput.
// Reset is synchronous and active high; it clears the queue, the sequencers,
// the output valid and the center, and sets the radius to 65536. Stalls on m_axis
// hold the back part only; the front keeps taking triangles until the queue fills.
module sphere_triangle_subdivide import sphsub_pkg::*; #(
  parameter int COORD_WIDTH  = 32,
  parameter int NORMAL_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // From bit 0: ax, ay, az, bx, by_coord, bz, cx, cy, cz, red_in, green_in,
  // blue_in, zero fill.
  input  logic [((9*COORD_WIDTH+24+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // From bit 0: px, py, pz, nx, ny, nz, red_out, green_out, blue_out, zero fill.
  output logic [((3*COORD_WIDTH+3*NORMAL_WIDTH+24+7)/8)*8-1:0] m_axis_tdata,
  output logic                    m_axis_tlast,
  // From bit 0: child (2 bits), degenerate, zero fill.
  output logic [7:0]              m_axis_tuser,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]  cfg_data
);

  localparam int W      = COORD_WIDTH;
  localparam int NW     = NORMAL_WIDTH;
  localparam int IN_RAW = 9 * W + 24;
  localparam int EW     = IN_RAW + 9 * (W + 1);

  logic [W-1:0]  center_x;
  logic [W-1:0]  center_y;
  logic [W-1:0]  center_z;
  logic [W-2:0]  radius;
  logic          push;
  logic          push_ready;
  logic [EW-1:0] push_data;
  logic          q_valid;
  logic          q_pop;
  logic [EW-1:0] q_data;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= (W-1)'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_CENTER_Z: center_z <= cfg_data;
        CFG_RADIUS:   radius   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  sphsub_front #(
    .W (W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata[IN_RAW-1:0]),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sphsub_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  sphsub_back #(
    .W  (W),
    .NW (NW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .radius        (radius),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  localparam logic signed [NW-1:0] N_ONE = NW'(1) << (NW - 2);

  // The twelfth vertex always closes the center child.
  a_last_child: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == LAST_CHILD)
    else $error("tlast on a vertex outside the last child");

  // The x and z normal components never exceed one in magnitude.
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $signed(m_axis_tdata[3*W +: NW]) <= N_ONE &&
      $signed(m_axis_tdata[3*W +: NW]) >= -N_ONE &&
      $signed(m_axis_tdata[3*W+2*NW +: NW]) <= N_ONE &&
      $signed(m_axis_tdata[3*W+2*NW +: NW]) >= -N_ONE)
    else $error("normal component out of range");

  // Without the degenerate flag the normal is never the zero vector.
  a_zero_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[2] |->
      m_axis_tdata[3*W +: 3*NW] != '0)
    else $error("zero normal without the degenerate flag");

endmodule
